// ===== design/ccfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccfd_pkg: shared types, constants and crc helpers for the frame deframer
// phase and status codes, register indexes, reflected crc byte updates
// ----------------------------------------------------------------------------
package ccfd_pkg;

    localparam logic [7:0] SOF_BYTE    = 8'hA5;
    localparam int unsigned HDR_BYTES  = 5;
    localparam int unsigned CFG_IDX_W  = 3;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC8_POLY   = 3'd0,
        CFG_CRC8_INIT   = 3'd1,
        CFG_CRC16_POLY  = 3'd2,
        CFG_CRC16_INIT  = 3'd3,
        CFG_MAX_PAYLOAD = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_CMD    = 3'd2,
        PH_DATA   = 3'd3,
        PH_TAIL   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_HDR_ERR  = 3'd2,
        ST_CRC_ERR  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // reflected crc8, lsb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    // reflected crc16, lsb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/crc_checked_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer: serial byte stream deframer with crc checks
// the result item is registered and shown in the cycle after its input item is accepted
// throughput: one item per cycle while the output side takes results; the crc byte
//   update and phase step are one level of logic ahead of the result register
// reset (i_rst_n low, synchronous): hunting, counters cleared, registers at
//   their defaults, no result pending
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream, tdata = rx_byte[7:0]
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: out_byte[7:0], payload_index[23:8], command_id[39:24],
    //        payload_length[55:40]
    output logic [55:0]                    o_m_axis_tdata,
    // tuser: in_payload[0], status[3:1]
    output logic [3:0]                     o_m_axis_tuser,
    // tlast: frame_end
    output logic                           o_m_axis_tlast,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ccfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import ccfd_pkg::*;

    // configuration registers
    logic [7:0]  r_crc8_poly, r_crc8_init;
    logic [15:0] r_crc16_poly, r_crc16_init, r_max_payload;

    // frame state
    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  r_crc8, n_crc8;
    logic [15:0] r_crc16, n_crc16;
    logic [7:0]  r_tail_lo, n_tail_lo;

    // result register
    logic        r_m_valid;
    logic [55:0] r_m_data, n_m_data;
    logic [3:0]  r_m_user, n_m_user;
    logic        r_m_last, n_m_last;

    // per item result fields
    logic        res_in_pl;
    logic [15:0] res_pl_idx, res_cmd, res_len;
    logic        res_fend;
    t_status     res_status;

    logic        s_accept;
    logic [16:0] data_next_cnt;
    logic [15:0] crc16_upd;

    // the result register frees when its item is taken, so a new item
    // can enter in the same cycle
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_m_axis_tlast  = r_m_last;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc8_poly   <= 8'h8C;
            r_crc8_init   <= 8'hFF;
            r_crc16_poly  <= 16'h8408;
            r_crc16_init  <= 16'hFFFF;
            r_max_payload <= 16'd119;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CRC8_POLY:   r_crc8_poly   <= i_cfg_data[7:0];
                CFG_CRC8_INIT:   r_crc8_init   <= i_cfg_data[7:0];
                CFG_CRC16_POLY:  r_crc16_poly  <= i_cfg_data;
                CFG_CRC16_INIT:  r_crc16_init  <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // running crc16 update, used by header, command and data phases
    assign crc16_upd     = crc16_byte(r_crc16, i_s_axis_tdata, r_crc16_poly);
    assign data_next_cnt = {1'b0, r_count} + 17'd1;

    // next state and result fields for the byte at the input
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_len      = r_len;
        n_cmd      = r_cmd;
        n_crc8     = r_crc8;
        n_crc16    = r_crc16;
        n_tail_lo  = r_tail_lo;
        res_in_pl  = 1'b0;
        res_pl_idx = '0;
        res_cmd    = '0;
        res_len    = '0;
        res_fend   = 1'b0;
        res_status = ST_BUSY;

        case (r_phase)
            PH_HEADER: begin
                n_crc16 = crc16_upd;
                if (r_count == 16'd1) begin
                    n_len = {r_len[15:8], i_s_axis_tdata};
                end else if (r_count == 16'd2) begin
                    n_len = {i_s_axis_tdata, r_len[7:0]};
                end
                if (r_count < 16'(HDR_BYTES - 1)) begin
                    n_crc8  = crc8_byte(r_crc8, i_s_axis_tdata, r_crc8_poly);
                    n_count = r_count + 16'd1;
                end else begin
                    // crc byte of the header
                    n_count = '0;
                    if (r_crc8 != i_s_axis_tdata) begin
                        res_fend   = 1'b1;
                        res_status = ST_HDR_ERR;
                        n_phase    = PH_HUNT;
                    end else if (r_len > r_max_payload) begin
                        res_len    = r_len;
                        res_fend   = 1'b1;
                        res_status = ST_OVERFLOW;
                        n_phase    = PH_HUNT;
                    end else begin
                        res_len = r_len;
                        n_phase = PH_CMD;
                    end
                end
            end
            PH_CMD: begin
                n_crc16 = crc16_upd;
                if (r_count == 16'd0) begin
                    n_cmd   = {8'd0, i_s_axis_tdata};
                    n_count = 16'd1;
                end else begin
                    n_cmd   = {i_s_axis_tdata, r_cmd[7:0]};
                    n_count = '0;
                    // empty payload skips straight to the crc tail
                    n_phase = (r_len == 16'd0) ? PH_TAIL : PH_DATA;
                end
                res_cmd = n_cmd;
                res_len = r_len;
            end
            PH_DATA: begin
                n_crc16    = crc16_upd;
                res_in_pl  = 1'b1;
                res_pl_idx = r_count;
                n_count    = data_next_cnt[15:0];
                if (data_next_cnt >= {1'b0, r_len}) begin
                    n_count = '0;
                    n_phase = PH_TAIL;
                end
                res_cmd = r_cmd;
                res_len = r_len;
            end
            PH_TAIL: begin
                res_cmd = r_cmd;
                res_len = r_len;
                if (r_count == 16'd0) begin
                    n_tail_lo = i_s_axis_tdata;
                    n_count   = 16'd1;
                end else begin
                    res_fend   = 1'b1;
                    res_status = ({i_s_axis_tdata, r_tail_lo} == r_crc16) ?
                                 ST_GOOD : ST_CRC_ERR;
                    n_count    = '0;
                    n_phase    = PH_HUNT;
                end
            end
            default: begin
                // hunting; unused phase codes land here too
                n_phase = PH_HUNT;
                n_count = '0;
                if (i_s_axis_tdata == SOF_BYTE) begin
                    n_crc8    = crc8_byte(r_crc8_init, i_s_axis_tdata, r_crc8_poly);
                    n_crc16   = crc16_byte(r_crc16_init, i_s_axis_tdata, r_crc16_poly);
                    n_len     = '0;
                    n_cmd     = '0;
                    n_tail_lo = '0;
                    n_count   = 16'd1;
                    n_phase   = PH_HEADER;
                end
            end
        endcase

        n_m_data = {res_len, res_cmd, res_pl_idx, i_s_axis_tdata};
        n_m_user = {res_status, res_in_pl};
        n_m_last = res_fend;
    end

    // frame state advances only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_len     <= '0;
            r_cmd     <= '0;
            r_crc8    <= 8'hFF;
            r_crc16   <= 16'hFFFF;
            r_tail_lo <= '0;
        end else if (s_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_len     <= n_len;
            r_cmd     <= n_cmd;
            r_crc8    <= n_crc8;
            r_crc16   <= n_crc16;
            r_tail_lo <= n_tail_lo;
        end
    end

    // result register, held while the output side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_m_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= n_m_data;
            r_m_user <= n_m_user;
            r_m_last <= n_m_last;
        end
    end

    // a shown frame end always leaves the deframer hunting
    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_last) |-> (r_phase == PH_HUNT))
        else $error("frame end shown while a frame is still open");

    // a shown payload byte lies inside the frame's payload length
    a_pl_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_user[0]) |-> (r_m_data[23:8] < r_len))
        else $error("payload index beyond payload length");

    // the data phase counter never reaches the payload length
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_count < r_len))
        else $error("data counter ran past payload length");

    // header phase counter stays between the length bytes and the crc byte
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_count >= 16'd1 && r_count <= 16'd4))
        else $error("header counter out of range");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for crc_checked_frame_deframer
// Builds byte streams of good and broken frames with a local copy of the
// register settings, predicts every result item from the accepted bytes and
// compares it field by field. Both stream sides stall at random, and the
// registers are rewritten between bursts once all results have drained.
// ----------------------------------------------------------------------------
module tb;
    import ccfd_pkg::*;

    localparam int unsigned CLK_HALF_NS   = 2;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned SETTLE_CYCLES = 3;
    localparam int unsigned STALL_LIMIT   = 2000; // cycles with no handshake at all
    localparam int unsigned IDLE_PCT      = 25;

    // what the driver works through, in order
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_CFG,
        OP_DRAIN    // hold off until every predicted result has come out
    } op_kind_t;

    typedef struct {
        op_kind_t    kind;
        logic [15:0] data;
        t_cfg_idx    idx;
    } pending_op_t;

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_HDR_CRC,
        FLAW_FRAME_CRC
    } frame_flaw_t;

    // one predicted result item
    typedef struct packed {
        logic [7:0]  data;
        logic        in_pl;
        logic [15:0] idx;
        logic [15:0] cmd;
        logic [15:0] len;
        logic        fend;
        t_status     st;
    } frame_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // stimulus side
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = 8'h00;
    logic        m_ready  = 1'b0;
    logic        cfg_valid = 1'b0;
    t_cfg_idx    cfg_idx  = CFG_CRC8_POLY;
    logic [15:0] cfg_data = 16'h0000;

    // dut outputs
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_data;
    logic [3:0]  m_user;
    logic        m_last;
    logic        cfg_ready;

    pending_op_t   pending[$];
    frame_result_t deframed_q[$];

    // register settings as the generator plans them
    logic [7:0]  gen_c8_poly  = 8'h8C;
    logic [7:0]  gen_c8_init  = 8'hFF;
    logic [15:0] gen_c16_poly = 16'h8408;
    logic [15:0] gen_c16_init = 16'hFFFF;
    logic [15:0] gen_max      = 16'd119;

    // predictor copy of the registers and of the deframer state
    logic [7:0]  c8_poly, c8_init;
    logic [15:0] c16_poly, c16_init, max_pl;
    t_phase      ph;
    logic [15:0] cnt, len_r, cmd_r, crc16_r;
    logic [7:0]  crc8_r, tail_lo;

    int unsigned n_bytes, n_results, n_cfg, n_payload;
    int unsigned n_good, n_hdr_err, n_crc_err, n_ovf;
    int unsigned errors, settle, idle_cycles;
    logic        calm;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (n_bytes >= 200) && (n_bytes < 330);

    crc_checked_frame_deframer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // bit-serial reflected crc; an 8-bit crc rides in the low byte
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb) crc = crc ^ poly;
        end
        return crc;
    endfunction

    function automatic void write_register(input t_cfg_idx idx, input logic [15:0] v);
        case (idx)
            CFG_CRC8_POLY:   c8_poly  = v[7:0];
            CFG_CRC8_INIT:   c8_init  = v[7:0];
            CFG_CRC16_POLY:  c16_poly = v;
            CFG_CRC16_INIT:  c16_init = v;
            CFG_MAX_PAYLOAD: max_pl   = v;
            default: ;
        endcase
    endfunction

    // advance the predicted deframer by one byte and return its result item
    function automatic frame_result_t deframe_byte(input logic [7:0] b);
        frame_result_t r;
        logic [15:0]   t;
        r.data  = b;
        r.in_pl = 1'b0;
        r.idx   = 16'd0;
        r.cmd   = 16'd0;
        r.len   = 16'd0;
        r.fend  = 1'b0;
        r.st    = ST_BUSY;
        case (ph)
            PH_HEADER: begin
                crc16_r = crc_step(crc16_r, b, c16_poly);
                if (cnt == 16'd1) len_r[7:0] = b;
                else if (cnt == 16'd2) len_r[15:8] = b;
                if (cnt < HDR_BYTES - 1) begin
                    t      = crc_step({8'h00, crc8_r}, b, {8'h00, c8_poly});
                    crc8_r = t[7:0];
                    cnt    = cnt + 16'd1;
                end else begin
                    // last header byte carries the crc8
                    cnt = 16'd0;
                    if (crc8_r != b) begin
                        r.fend = 1'b1;
                        r.st   = ST_HDR_ERR;
                        ph     = PH_HUNT;
                    end else if (len_r > max_pl) begin
                        r.len  = len_r;
                        r.fend = 1'b1;
                        r.st   = ST_OVERFLOW;
                        ph     = PH_HUNT;
                    end else begin
                        r.len = len_r;
                        ph    = PH_CMD;
                    end
                end
            end
            PH_CMD: begin
                crc16_r = crc_step(crc16_r, b, c16_poly);
                if (cnt == 16'd0) begin
                    cmd_r = {8'h00, b};
                    cnt   = 16'd1;
                end else begin
                    cmd_r[15:8] = b;
                    cnt         = 16'd0;
                    // empty payload skips straight to the crc tail
                    ph = (len_r == 16'd0) ? PH_TAIL : PH_DATA;
                end
                r.cmd = cmd_r;
                r.len = len_r;
            end
            PH_DATA: begin
                crc16_r = crc_step(crc16_r, b, c16_poly);
                r.in_pl = 1'b1;
                r.idx   = cnt;
                cnt     = cnt + 16'd1;
                if (cnt >= len_r) begin
                    cnt = 16'd0;
                    ph  = PH_TAIL;
                end
                r.cmd = cmd_r;
                r.len = len_r;
            end
            PH_TAIL: begin
                r.cmd = cmd_r;
                r.len = len_r;
                if (cnt == 16'd0) begin
                    tail_lo = b;
                    cnt     = 16'd1;
                end else begin
                    r.fend = 1'b1;
                    r.st   = ({b, tail_lo} == crc16_r) ? ST_GOOD : ST_CRC_ERR;
                    cnt    = 16'd0;
                    ph     = PH_HUNT;
                end
            end
            default: begin
                // hunting; only the start byte opens a frame
                ph  = PH_HUNT;
                cnt = 16'd0;
                if (b == SOF_BYTE) begin
                    t       = crc_step({8'h00, c8_init}, b, {8'h00, c8_poly});
                    crc8_r  = t[7:0];
                    crc16_r = crc_step(c16_init, b, c16_poly);
                    len_r   = 16'd0;
                    cmd_r   = 16'd0;
                    tail_lo = 8'h00;
                    cnt     = 16'd1;
                    ph      = PH_HEADER;
                end
            end
        endcase
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        pending.push_back('{kind: OP_BYTE, data: {8'h00, b}, idx: CFG_CRC8_POLY});
    endtask

    // drain, then rewrite every register; the generator follows the new values
    task automatic set_config(input logic [7:0] p8, input logic [7:0] i8,
                              input logic [15:0] p16, input logic [15:0] i16,
                              input logic [15:0] mx);
        pending.push_back('{kind: OP_DRAIN, data: 16'h0000, idx: CFG_CRC8_POLY});
        pending.push_back('{kind: OP_CFG, data: {8'h00, p8}, idx: CFG_CRC8_POLY});
        pending.push_back('{kind: OP_CFG, data: {8'h00, i8}, idx: CFG_CRC8_INIT});
        pending.push_back('{kind: OP_CFG, data: p16, idx: CFG_CRC16_POLY});
        pending.push_back('{kind: OP_CFG, data: i16, idx: CFG_CRC16_INIT});
        pending.push_back('{kind: OP_CFG, data: mx, idx: CFG_MAX_PAYLOAD});
        gen_c8_poly  = p8;
        gen_c8_init  = i8;
        gen_c16_poly = p16;
        gen_c16_init = i16;
        gen_max      = mx;
    endtask

    // one frame; a length above the limit or a header crc flaw sends the header alone
    task automatic queue_frame(input logic [15:0] plen, input logic [15:0] cmd,
                               input frame_flaw_t flaw);
        logic [7:0]  fb[$];
        logic [15:0] t;
        logic [7:0]  hdr_crc;
        fb = {SOF_BYTE, plen[7:0], plen[15:8], 8'($urandom_range(0, 255))};
        t  = {8'h00, gen_c8_init};
        foreach (fb[i]) t = crc_step(t, fb[i], {8'h00, gen_c8_poly});
        hdr_crc = t[7:0];
        if (flaw == FLAW_HDR_CRC) hdr_crc = hdr_crc ^ 8'(1 << $urandom_range(0, 7));
        fb.push_back(hdr_crc);
        if (flaw != FLAW_HDR_CRC && plen <= gen_max) begin
            fb.push_back(cmd[7:0]);
            fb.push_back(cmd[15:8]);
            // start bytes show up inside payloads too
            for (int unsigned i = 0; i < plen; i++)
                fb.push_back(($urandom_range(0, 9) == 0) ? SOF_BYTE
                                                         : 8'($urandom_range(0, 255)));
            t = gen_c16_init;
            foreach (fb[i]) t = crc_step(t, fb[i], gen_c16_poly);
            if (flaw == FLAW_FRAME_CRC) t = t ^ 16'(1 << $urandom_range(0, 15));
            fb.push_back(t[7:0]);
            fb.push_back(t[15:8]);
        end
        foreach (fb[i]) push_byte(fb[i]);
    endtask

    // mostly well-formed frames with short payloads, some damaged, some noise
    task automatic queue_random_traffic(input int unsigned target);
        int unsigned start, roll, cap, wide, plen, n;
        logic [15:0] cmd;
        start = pending.size();
        while (pending.size() - start < target) begin
            roll = $urandom_range(0, 99);
            cmd  = 16'($urandom_range(0, 65535));
            cap  = (gen_max < 12) ? gen_max : 12;
            wide = (gen_max < 40) ? gen_max : 40;
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, wide)
                                               : $urandom_range(0, cap);
            if (roll < 8) begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(($urandom_range(0, 9) == 0) ? SOF_BYTE
                                                                 : 8'($urandom_range(0, 255)));
            end else if (roll < 16) begin
                queue_frame(16'(plen), cmd, FLAW_HDR_CRC);
            end else if (roll < 26) begin
                queue_frame(16'(plen), cmd, FLAW_FRAME_CRC);
            end else if (roll < 34 && gen_max != 16'hFFFF) begin
                plen = int'(gen_max) + 1 + $urandom_range(0, 20);
                if (plen > 65535 || $urandom_range(0, 3) == 0) plen = 65535;
                queue_frame(16'(plen), cmd, FLAW_NONE);
            end else begin
                queue_frame(16'(plen), cmd, FLAW_NONE);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: presents bytes and register writes, predicts on acceptance
    always @(posedge i_clk) begin : driver
        pending_op_t   op;
        frame_result_t r;
        logic          nxt_s, nxt_c;
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
            c8_poly   = 8'h8C;
            c8_init   = 8'hFF;
            c16_poly  = 16'h8408;
            c16_init  = 16'hFFFF;
            max_pl    = 16'd119;
            ph        = PH_HUNT;
            cnt       = 16'd0;
            len_r     = 16'd0;
            cmd_r     = 16'd0;
            crc8_r    = 8'hFF;
            crc16_r   = 16'hFFFF;
            tail_lo   = 8'h00;
            settle    = 0;
        end else begin
            nxt_s = s_valid;
            nxt_c = cfg_valid;
            if (s_valid && s_ready) begin
                r = deframe_byte(s_data);
                deframed_q.push_back(r);
                n_bytes++;
                nxt_s = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                write_register(cfg_idx, cfg_data);
                n_cfg++;
                nxt_c = 1'b0;
            end
            if (!nxt_s && !nxt_c && pending.size() != 0) begin
                op = pending[0];
                if (op.kind == OP_DRAIN) begin
                    // wait out every result plus the pipeline before touching registers
                    if (deframed_q.size() != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYCLES) begin
                        settle++;
                    end else begin
                        void'(pending.pop_front());
                        settle = 0;
                    end
                end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                    void'(pending.pop_front());
                    if (op.kind == OP_BYTE) begin
                        nxt_s = 1'b1;
                        s_data <= op.data[7:0];
                    end else begin
                        nxt_c = 1'b1;
                        cfg_idx  <= op.idx;
                        cfg_data <= op.data;
                    end
                end
            end
            // a single assignment per cycle keeps back-to-back items glitch free
            s_valid   <= nxt_s;
            cfg_valid <= nxt_c;
        end
    end

    // monitor: random back-pressure and field-by-field compare
    always @(posedge i_clk) begin : monitor
        frame_result_t want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (deframed_q.size() == 0) begin
                    $display({"%0t: unexpected result item, expected none, ",
                              "actual tdata %0h tuser %0h tlast %0b"},
                             $time, m_data, m_user, m_last);
                    errors++;
                end else begin
                    want = deframed_q.pop_front();
                    check_field("out_byte",       16'(want.data),  16'(m_data[7:0]));
                    check_field("payload_index",  want.idx,        m_data[23:8]);
                    check_field("command_id",     want.cmd,        m_data[39:24]);
                    check_field("payload_length", want.len,        m_data[55:40]);
                    check_field("in_payload",     16'(want.in_pl), 16'(m_user[0]));
                    check_field("status",         16'(want.st),    16'(m_user[3:1]));
                    check_field("frame_end",      16'(want.fend),  16'(m_last));
                    if (want.in_pl) n_payload++;
                    case (want.st)
                        ST_GOOD:     n_good++;
                        ST_HDR_ERR:  n_hdr_err++;
                        ST_CRC_ERR:  n_crc_err++;
                        ST_OVERFLOW: n_ovf++;
                        default: ;
                    endcase
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("[crc_checked_frame_deframer] ERROR");
                $finish;
            end
        end
    end

    initial begin
        n_bytes = 0;  n_results = 0; n_cfg = 0;   n_payload = 0;
        n_good = 0;   n_hdr_err = 0; n_crc_err = 0; n_ovf = 0;
        errors = 0;   settle = 0;    idle_cycles = 0;

        // directed: registers at reset values
        push_byte(8'h00);                              // ignored while hunting
        queue_frame(16'd0, 16'hFFFF, FLAW_NONE);       // empty payload, good crc
        queue_frame(16'd1, 16'h1234, FLAW_HDR_CRC);    // header crc error
        queue_frame(16'hFFFF, 16'h0000, FLAW_NONE);    // longest length, overflow
        queue_frame(16'd1, 16'h0000, FLAW_FRAME_CRC);  // frame crc error

        // reset values written back explicitly
        set_config(8'h8C, 8'hFF, 16'h8408, 16'hFFFF, 16'd119);
        queue_random_traffic(50);
        // all zero: only empty payloads fit
        set_config(8'h00, 8'h00, 16'h0000, 16'h0000, 16'd0);
        queue_random_traffic(30);
        // all ones, plus one long payload
        set_config(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_frame(16'd260, 16'($urandom_range(0, 65535)), FLAW_NONE);
        queue_random_traffic(30);
        // random polynomials and start values
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 40)));
        queue_random_traffic(45);
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(1, 6)));
        queue_random_traffic(45);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and every result back
        while (pending.size() != 0 || s_valid || cfg_valid || deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (deframed_q.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, deframed_q.size());
            errors += deframed_q.size();
        end

        $display("run covered %0d bytes in, %0d result items out (%0d payload)",
                 n_bytes, n_results, n_payload);
        $display("%0d register writes; frame ends: %0d good, %0d header crc, %0d frame crc, %0d overflow",
                 n_cfg, n_good, n_hdr_err, n_crc_err, n_ovf);
        if (errors == 0)
            $display("[crc_checked_frame_deframer] OK");
        else
            $display("[crc_checked_frame_deframer] ERROR");
        $finish;
    end

endmodule

// ===== crc_checked_frame_deframer.f =====
design/ccfd_pkg.sv
design/crc_checked_frame_deframer.sv
tb/sv/tb.sv
